>>> rtl/kvtlv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvtlv_pkg
// Shared types and codes for the key-value TLV serializer.
// ----------------------------------------------------------------------------
package kvtlv_pkg;

   localparam int unsigned CMD_BYTES = 13;
   localparam int unsigned CMD_BITS  = CMD_BYTES * 8;
   localparam int unsigned CNT_BITS  = 4;

   localparam logic [1:0] REQ_RECORD  = 2'd0;
   localparam logic [1:0] REQ_PAIR    = 2'd1;
   localparam logic [1:0] REQ_PAYLOAD = 2'd2;
   localparam logic [1:0] REQ_UNUSED  = 2'd3;

   localparam logic [1:0] VT_BOOLEAN = 2'd0;
   localparam logic [1:0] VT_INTEGER = 2'd1;
   localparam logic [1:0] VT_STRING  = 2'd2;
   localparam logic [1:0] VT_DOUBLE  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DROP    = 2'd1;
   localparam logic [1:0] ST_ABANDON = 2'd2;

   localparam logic [CNT_BITS-1:0] LEN_ONE    = 4'd1;
   localparam logic [CNT_BITS-1:0] LEN_WORD   = 4'd4;
   localparam logic [CNT_BITS-1:0] LEN_DESC   = 4'd5;
   localparam logic [CNT_BITS-1:0] LEN_INT    = 4'd9;
   localparam logic [CNT_BITS-1:0] LEN_DOUBLE = 4'd13;

   localparam logic [7:0] FIT_FLAG = 8'h20;

   // one queued job: bytes packed little-end first, byte count, status
   typedef struct packed {
      logic [CMD_BITS-1:0] data;
      logic [CNT_BITS-1:0] nbytes;
      logic [1:0]          status;
   } cmd_type;

endpackage
`default_nettype wire

>>> rtl/kvtlv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvtlv_front
// Classifies input words, tracks pending string bytes and builds byte jobs.
// ----------------------------------------------------------------------------
module kvtlv_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [1:0]            req_type,
   input  wire logic [31:0]           req_pair_count,
   input  wire logic [31:0]           req_key_id,
   input  wire logic [1:0]            req_value_type,
   input  wire logic signed [31:0]    req_int_value,
   input  wire logic [63:0]           req_double_bits,
   input  wire logic [31:0]           req_string_length,
   input  wire logic [7:0]            req_payload_byte,
   output logic                       push,
   output kvtlv_pkg::cmd_type         cmd
);
   import kvtlv_pkg::*;

   logic [31:0] remaining_ff, remaining_in;
   logic        pending;
   logic [7:0]  desc;
   logic [31:0] int_bits;

   assign pending  = (remaining_ff != 32'd0);
   assign int_bits = req_int_value;

   always_comb begin
      remaining_in = remaining_ff;
      push         = 1'b0;
      cmd.data     = '0;
      cmd.nbytes   = LEN_ONE;
      cmd.status   = ST_OK;
      desc         = {req_value_type, 6'd0};
      unique case (req_type)
         REQ_PAYLOAD: begin
            push = accept;
            if (pending) begin
               cmd.data[7:0] = req_payload_byte;
               remaining_in  = remaining_ff - 32'd1;
            end else begin
               cmd.status = ST_DROP;
            end
         end
         REQ_RECORD: begin
            push            = accept;
            remaining_in    = 32'd0;
            cmd.status      = pending ? ST_ABANDON : ST_OK;
            cmd.data[31:0]  = req_pair_count;
            cmd.nbytes      = LEN_WORD;
         end
         REQ_PAIR: begin
            push           = accept;
            remaining_in   = 32'd0;
            cmd.status     = pending ? ST_ABANDON : ST_OK;
            cmd.data[31:0] = req_key_id;
            cmd.nbytes     = LEN_DESC;
            unique case (req_value_type)
               VT_BOOLEAN: begin
                  desc[0] = (int_bits != 32'd0);
               end
               VT_INTEGER: begin
                  if (int_bits[31:5] == 27'd0) begin
                     desc = desc | FIT_FLAG | {3'd0, int_bits[4:0]};
                  end else begin
                     cmd.data[71:40] = int_bits;
                     cmd.nbytes      = LEN_INT;
                  end
               end
               VT_STRING: begin
                  remaining_in = req_string_length;
                  if (req_string_length[31:5] == 27'd0) begin
                     desc = desc | FIT_FLAG | {3'd0, req_string_length[4:0]};
                  end else begin
                     cmd.data[71:40] = req_string_length;
                     cmd.nbytes      = LEN_INT;
                  end
               end
               VT_DOUBLE: begin
                  cmd.data[103:40] = req_double_bits;
                  cmd.nbytes       = LEN_DOUBLE;
               end
               default: begin
               end
            endcase
            cmd.data[39:32] = desc;
         end
         REQ_UNUSED: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 32'd0;
      end else if (push) begin
         remaining_ff <= remaining_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/kvtlv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvtlv_queue
// Small job queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module kvtlv_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  kvtlv_pkg::cmd_type      push_cmd,
   input  wire logic               pop,
   output logic                    full,
   output logic                    not_empty,
   output kvtlv_pkg::cmd_type      head_cmd
);
   import kvtlv_pkg::*;

   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_W-1:0]    FULL_CNT = CNT_W'(DEPTH);

   cmd_type               slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> rtl/kvtlv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvtlv_back
// Walks the head job one byte per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module kvtlv_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               job_valid,
   input  kvtlv_pkg::cmd_type      job,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last_of_run,
   output logic [1:0]              rsp_status
);
   import kvtlv_pkg::*;

   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic                valid_ff;
   logic [7:0]          byte_ff;
   logic                last_ff;
   logic [1:0]          status_ff;
   logic                load;
   logic                step;
   logic                is_last;

   assign load    = !valid_ff || !rsp_stall;
   assign step    = load && job_valid;
   assign is_last = (idx_ff == job.nbytes - 1'b1);
   assign pop     = step && is_last;
   assign idx_in  = is_last ? '0 : idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= job_valid;
         end
         if (step) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         byte_ff   <= job.data[{idx_ff, 3'b000} +: 8];
         last_ff   <= is_last;
         status_ff <= job.status;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_status      = status_ff;

endmodule
`default_nettype wire

>>> rtl/kv_tlv_record_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kv_tlv_record_serializer
// Key-value record to little-endian TLV byte stream serializer.
// ----------------------------------------------------------------------------
// The block emits at most one stream byte per cycle, one in every cycle that
// the output is not stalled and a job is waiting. A classifier accepts one
// input word per cycle as long as the job queue (QUEUE_DEPTH entries) has
// room; each word but an unused type becomes a job of 1 to 13 bytes that the
// byte sequencer drains one byte per cycle while the output is not stalled.
// String payload words therefore flow at one per cycle; a record start is a
// 4-byte job and a pair header 5, 9 or 13 bytes; the output is registered.
module kv_tlv_record_serializer #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_type,
   input  wire logic [31:0]           req_pair_count,
   input  wire logic [31:0]           req_key_id,
   input  wire logic [1:0]            req_value_type,
   input  wire logic signed [31:0]    req_int_value,
   input  wire logic [63:0]           req_double_bits,
   input  wire logic [31:0]           req_string_length,
   input  wire logic [7:0]            req_payload_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_of_run,
   output logic [1:0]                 rsp_status
);
   import kvtlv_pkg::*;

   logic    accept;
   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_not_empty;
   cmd_type new_cmd;
   cmd_type head_cmd;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   kvtlv_front u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_type          (req_type),
      .req_pair_count    (req_pair_count),
      .req_key_id        (req_key_id),
      .req_value_type    (req_value_type),
      .req_int_value     (req_int_value),
      .req_double_bits   (req_double_bits),
      .req_string_length (req_string_length),
      .req_payload_byte  (req_payload_byte),
      .push              (push),
      .cmd               (new_cmd)
   );

   kvtlv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (new_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   kvtlv_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (q_not_empty),
      .job             (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_status      (rsp_status)
   );

endmodule
`default_nettype wire
